// File: hdl/midi_track_event_parser_macros.svh
// assertion macros for the midi track event parser
// used by the top level only; clk and rst are taken from the including scope
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtep assertion failed");

// next-cycle implication
`define MTEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtep assertion failed");

`else

`define MTEP_ASSERT_IMP(lbl, ante, cons)
`define MTEP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hdl/mtep_pkg.sv
// types and constants shared by the midi track event parser modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       track_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] event_tick;
    logic [23:0] tempo_us;
  } out_word_t;

  // status from the parse core to the top level
  typedef struct packed {
    logic fire;
    logic done;
  } core_stat_t;

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_TEMPO   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

endpackage

`default_nettype wire

// File: hdl/mtep_core.sv
// parse state of one track and the per-byte decode
// depends on mtep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtep_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire mtep_pkg::in_word_t  item,
  output mtep_pkg::core_stat_t   stat,
  output mtep_pkg::out_word_t    res
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_SYSEX_LEN = 4'd6,
    PH_SKIP      = 4'd7,
    PH_TEMPO     = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] tick_count, tick_count_next;
  logic [7:0]  last_status, last_status_next;
  logic [7:0]  current_status, current_status_next;
  logic [27:0] varlen_acc, varlen_acc_next;
  logic [2:0]  varlen_bytes, varlen_bytes_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [27:0] skip_left, skip_left_next;
  logic [7:0]  held_data, held_data_next;
  logic [23:0] tempo_acc, tempo_acc_next;
  logic        track_done, track_done_next;

  logic        fire;

  always_comb begin
    phase_t      ph;
    logic [31:0] tk;
    logic [7:0]  rs, cs, mt, hd, b, st;
    logic [27:0] va, sl, vl_acc, sl_dec;
    logic [2:0]  vb;
    logic [23:0] ta;
    logic        dn, vl_done;

    b = item.data_byte;
    // track start clears the track state before the byte is parsed
    ph = item.track_start ? PH_DELTA : phase;
    tk = item.track_start ? 32'd0 : tick_count;
    rs = item.track_start ? 8'd0 : last_status;
    cs = item.track_start ? 8'd0 : current_status;
    va = item.track_start ? 28'd0 : varlen_acc;
    vb = item.track_start ? 3'd0 : varlen_bytes;
    mt = item.track_start ? 8'd0 : meta_type;
    sl = item.track_start ? 28'd0 : skip_left;
    hd = item.track_start ? 8'd0 : held_data;
    ta = item.track_start ? 24'd0 : tempo_acc;
    dn = item.track_start ? 1'b0 : track_done;

    phase_next          = ph;
    tick_count_next     = tk;
    last_status_next    = rs;
    current_status_next = cs;
    varlen_acc_next     = va;
    varlen_bytes_next   = vb;
    meta_type_next      = mt;
    skip_left_next      = sl;
    held_data_next      = hd;
    tempo_acc_next      = ta;
    track_done_next     = dn;

    fire = 1'b0;
    res  = '0;

    vl_acc  = {va[20:0], b[6:0]};
    vl_done = !b[7] || (vb >= 3'd3);
    sl_dec  = sl - 28'd1;
    st      = (b[7]) ? b : rs;

    if (!dn) begin
      unique case (ph)
        PH_DELTA: begin
          varlen_acc_next   = vl_acc;
          varlen_bytes_next = vb + 3'd1;
          if (vl_done) begin
            tick_count_next   = tk + {4'd0, vl_acc};
            varlen_acc_next   = '0;
            varlen_bytes_next = '0;
            phase_next        = PH_STATUS;
          end
        end
        PH_STATUS: begin
          last_status_next    = st;
          current_status_next = st;
          varlen_acc_next     = '0;
          varlen_bytes_next   = '0;
          if (st == ST_META) begin
            if (!b[7]) begin
              meta_type_next = b;
              phase_next     = PH_META_LEN;
            end else begin
              phase_next = PH_META_TYPE;
            end
          end else if (st == ST_SYSEX || st == ST_SYSEX_ESC) begin
            phase_next = PH_SYSEX_LEN;
            // data byte in status position opens the sysex length
            if (!b[7]) begin
              skip_left_next = {21'd0, b[6:0]};
              phase_next     = (b[6:0] != 7'd0) ? PH_SKIP : PH_DELTA;
            end
          end else if (!b[7]) begin
            if (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) begin
              fire            = 1'b1;
              res.kind        = KIND_CHANNEL;
              res.status_byte = st;
              res.first_data  = b;
              phase_next      = PH_DELTA;
            end else begin
              held_data_next = b;
              phase_next     = PH_DATA2;
            end
          end else begin
            phase_next = PH_DATA1;
          end
        end
        PH_DATA1: begin
          if (cs[7:4] == HI_PROGRAM || cs[7:4] == HI_PRESSURE) begin
            fire            = 1'b1;
            res.kind        = KIND_CHANNEL;
            res.status_byte = cs;
            res.first_data  = b;
            phase_next      = PH_DELTA;
          end else begin
            held_data_next = b;
            phase_next     = PH_DATA2;
          end
        end
        PH_DATA2: begin
          fire            = 1'b1;
          res.kind        = KIND_CHANNEL;
          res.status_byte = cs;
          res.first_data  = hd;
          res.second_data = b;
          phase_next      = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_type_next    = b;
          varlen_acc_next   = '0;
          varlen_bytes_next = '0;
          phase_next        = PH_META_LEN;
        end
        PH_META_LEN: begin
          varlen_acc_next   = vl_acc;
          varlen_bytes_next = vb + 3'd1;
          if (vl_done) begin
            varlen_acc_next   = '0;
            varlen_bytes_next = '0;
            if (mt == META_END) begin
              fire            = 1'b1;
              res.kind        = KIND_END;
              track_done_next = 1'b1;
              phase_next      = PH_DELTA;
            end else if (mt == META_TEMPO && vl_acc == 28'd3) begin
              tempo_acc_next = '0;
              skip_left_next = 28'd3;
              phase_next     = PH_TEMPO;
            end else begin
              skip_left_next = vl_acc;
              phase_next     = (vl_acc != 28'd0) ? PH_SKIP : PH_DELTA;
            end
          end
        end
        PH_SYSEX_LEN: begin
          varlen_acc_next   = vl_acc;
          varlen_bytes_next = vb + 3'd1;
          if (vl_done) begin
            varlen_acc_next   = '0;
            varlen_bytes_next = '0;
            skip_left_next    = vl_acc;
            phase_next        = (vl_acc != 28'd0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_SKIP: begin
          skip_left_next = sl_dec;
          if (sl_dec == 28'd0) begin
            phase_next = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          tempo_acc_next = {ta[15:0], b};
          skip_left_next = sl_dec;
          if (sl_dec == 28'd0) begin
            fire         = 1'b1;
            res.kind     = KIND_TEMPO;
            res.tempo_us = {ta[15:0], b};
            phase_next   = PH_DELTA;
          end
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase

      // last byte of the chunk ends the track, with a word only if none went out
      if (item.track_last && !track_done_next) begin
        track_done_next = 1'b1;
        if (!fire) begin
          fire     = 1'b1;
          res      = '0;
          res.kind = KIND_END;
        end
      end
    end

    res.event_tick = tick_count_next;
  end

  assign stat.fire = fire;
  assign stat.done = track_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      tick_count     <= '0;
      last_status    <= '0;
      current_status <= '0;
      varlen_acc     <= '0;
      varlen_bytes   <= '0;
      meta_type      <= '0;
      skip_left      <= '0;
      held_data      <= '0;
      tempo_acc      <= '0;
      track_done     <= 1'b0;
    end else if (en) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      last_status    <= last_status_next;
      current_status <= current_status_next;
      varlen_acc     <= varlen_acc_next;
      varlen_bytes   <= varlen_bytes_next;
      meta_type      <= meta_type_next;
      skip_left      <= skip_left_next;
      held_data      <= held_data_next;
      tempo_acc      <= tempo_acc_next;
      track_done     <= track_done_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/midi_track_event_parser.sv
// MIDI track event parser: takes track chunk bytes, one word per cycle when
// not stalled, and gives channel messages, tempo changes and end of track.
// Channel "item" carries one byte word (data_byte, track_start, track_last).
// Channel "result" carries one event word (kind, status_byte, first_data,
// second_data, event_tick, tempo_us); kind 0 channel, 1 tempo, 2 end.
// Both channels: a word moves on a rising edge with valid high, stall low.
// Each accepted byte is decoded against the parse state in the cycle it is
// accepted; its event word, if any, shows on result in the next cycle.
// Throughput is one byte per cycle while item_stall is low; the single
// result register follows the decode logic.
// A byte gives at most one event; many bytes (delta, meta bodies) give none.
// item_stall rises only while a result word is held and result_stall is high;
// a byte is then taken in the same cycle the held word leaves.
// Reset (rst, synchronous) clears the parse state and drops any held word.
// Bytes after the end of a track are taken and ignored until track_start.
// track_start on a byte clears tick, running status and state before that
// byte is parsed.
// Depends on mtep_pkg, mtep_core and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire mtep_pkg::in_word_t  item,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output mtep_pkg::out_word_t      result
);
  import mtep_pkg::*;

  logic       accept;
  core_stat_t stat;
  out_word_t  res;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  mtep_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .item (item),
    .stat (stat),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= stat.fire;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // payload holds while stalled since accept is low then
  always_ff @(posedge clk) begin
    if (accept && stat.fire) begin
      result <= res;
    end
  end

  `MTEP_ASSERT_IMP(a_kind_known, result_valid, result.kind == KIND_CHANNEL || result.kind == KIND_TEMPO || result.kind == KIND_END)
  `MTEP_ASSERT_IMP(a_non_channel_zero, result_valid && result.kind != KIND_CHANNEL, result.status_byte == 8'd0 && result.first_data == 8'd0 && result.second_data == 8'd0)
  `MTEP_ASSERT_IMP(a_silent_after_done, accept && !item.track_start && stat.done, !stat.fire)
  `MTEP_ASSERT_NXT(a_fire_shows, accept && stat.fire, result_valid && result.kind == $past(res.kind))

endmodule

`default_nettype wire
